// ----- rtl/core/lbds_pkg.sv -----
// Package for the debounced-speed LED breathing block: types, codes and reset values.
package lbds_pkg;

    // Quarter-wave table holds QUARTER_POINTS + 1 entries, within reach of the 6-bit index
    localparam int QUARTER_POINTS = 32;

    // Input item codes
    typedef enum logic [0:0] {
        CMD_TICK        = 1'b0,
        CMD_TABLE_WRITE = 1'b1
    } command_t;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_DEBOUNCE_COUNT    = 8'd0,
        CFG_SHORT_PRESS_TICKS = 8'd1,
        CFG_LONG_PRESS_TICKS  = 8'd2,
        CFG_UPDATE_DIVIDER    = 8'd3
    } cfg_index_t;

    typedef logic [15:0] cfg_data_t;
    typedef logic [8:0]  duty_t;
    typedef logic [2:0]  level_t;

    // Configuration reset values
    localparam logic [7:0]  DEBOUNCE_COUNT_RST    = 8'd10;
    localparam logic [15:0] SHORT_PRESS_TICKS_RST = 16'd20;
    localparam logic [15:0] LONG_PRESS_TICKS_RST  = 16'd2048;
    localparam logic [4:0]  UPDATE_DIVIDER_RST    = 5'd16;

    // Duty and level constants
    localparam duty_t  DUTY_IDLE = 9'd511;
    localparam duty_t  DUTY_MID  = 9'd256;
    localparam level_t LEVEL_MAX = 3'd5;

endpackage

// ----- rtl/core/led_breathing_debounced_speed.sv -----
// Top level of the LED breathing controller with debounced speed button and cosine table.
// A tick that produces a duty value reads the table into the read stage at its accepting
// edge; the output register loads from the read stage once the output side is free.
// Throughput: one transaction per cycle unless the output holds off the read stage; the
// single-port table is read at most once per tick, written once per in-range table write.
// Reset: control state and configuration registers take their reset values asynchronously;
// the table is undefined until written and needs no clearing pass.
module led_breathing_debounced_speed (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic                  button_level,
    input  logic [5:0]            table_index,
    input  logic [7:0]            table_value,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output lbds_pkg::duty_t       duty_value,
    output lbds_pkg::level_t      speed_level,
    output logic                  stable_level,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lbds_pkg::cfg_index_t  cfg_index,
    input  lbds_pkg::cfg_data_t   cfg_data
);
    import lbds_pkg::*;

    localparam int DEPTH = QUARTER_POINTS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(4 * QUARTER_POINTS + 17);

    localparam logic [PW-1:0] PH_Q1  = PW'(QUARTER_POINTS);
    localparam logic [PW-1:0] PH_Q2  = PW'(2 * QUARTER_POINTS);
    localparam logic [PW-1:0] PH_Q3  = PW'(3 * QUARTER_POINTS);
    localparam logic [PW-1:0] PH_TOP = PW'(4 * QUARTER_POINTS);

    // Configuration registers
    logic [7:0]  debounce_count_reg;
    logic [15:0] short_press_reg;
    logic [15:0] long_press_reg;
    logic [4:0]  update_divider_reg;

    // Tick state
    logic          last_raw_reg,  last_raw_next;
    logic [7:0]    agree_reg,     agree_next;
    logic          debounced_reg, debounced_next;
    logic [15:0]   press_reg,     press_next;
    level_t        level_reg,     level_next;
    logic [PW-1:0] phase_reg,     phase_next;
    logic [4:0]    tdiv_reg,      tdiv_next;

    // Table memory and read port
    logic [7:0]    table_mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          rd_en;

    // Read stage
    logic   s1_valid_reg;
    logic   s1_idle_reg,   s1_idle_next;
    logic   s1_neg_reg,    s1_neg_next;
    level_t s1_level_reg;
    logic   s1_stable_reg;
    logic   s1_advance;

    // Output register
    logic   out_valid_reg;
    duty_t  duty_reg;
    level_t level_out_reg;
    logic   stable_out_reg;

    logic   in_accept;
    logic   tick;
    logic   emit;
    logic   tdiv_hit;
    logic [4:0]    tdiv_inc;
    logic [PW-1:0] phase_mid;
    logic [PW-1:0] phase_sum;
    logic [PW-1:0] phase_new;
    logic [PW-1:0] idx_wide;
    duty_t         duty_calc;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;
    assign tick       = in_accept && (command == CMD_TICK);
    assign wr_en      = in_accept && (command == CMD_TABLE_WRITE)
                        && (32'(table_index) <= 32'(QUARTER_POINTS));
    assign wr_addr    = AW'(table_index);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg <= DEBOUNCE_COUNT_RST;
            short_press_reg    <= SHORT_PRESS_TICKS_RST;
            long_press_reg     <= LONG_PRESS_TICKS_RST;
            update_divider_reg <= UPDATE_DIVIDER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_COUNT:    debounce_count_reg <= cfg_data[7:0];
                CFG_SHORT_PRESS_TICKS: short_press_reg    <= cfg_data;
                CFG_LONG_PRESS_TICKS:  long_press_reg     <= cfg_data;
                CFG_UPDATE_DIVIDER:    update_divider_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Tick update: divider, debounce, press handling, phase step
    always_comb
    begin
        tdiv_inc       = tdiv_reg + 5'd1;
        last_raw_next  = last_raw_reg;
        agree_next     = agree_reg;
        debounced_next = debounced_reg;
        press_next     = press_reg;
        level_next     = level_reg;
        phase_mid      = phase_reg;

        // debounce on consecutive equal samples
        if (button_level != last_raw_reg)
        begin
            last_raw_next = button_level;
            agree_next    = 8'd0;
        end
        else
        begin
            if (agree_reg <= debounce_count_reg && agree_reg != 8'hFF)
                agree_next = agree_reg + 8'd1;
            if (agree_next == debounce_count_reg)
                debounced_next = button_level;
        end

        // press length and release action
        if (!debounced_next)
        begin
            if (press_reg != 16'hFFFF)
                press_next = press_reg + 16'd1;
        end
        else
        begin
            if (press_reg >= long_press_reg)
            begin
                level_next = '0;
                phase_mid  = '0;
            end
            else if (press_reg >= short_press_reg && level_reg < LEVEL_MAX)
            begin
                level_next = level_reg + 3'd1;
            end
            press_next = '0;
        end

        // phase step and wrap
        tdiv_hit  = (tdiv_inc == update_divider_reg);
        tdiv_next = tdiv_hit ? 5'd0 : tdiv_inc;
        phase_sum = phase_mid + (PW'(1) << (level_next - 3'd1));
        phase_new = (phase_sum > PH_TOP) ? '0 : phase_sum;
        emit      = tdiv_hit;
        rd_en     = tdiv_hit && (level_next != '0);
        phase_next = rd_en ? phase_new : phase_mid;

        // quadrant mirror and sign
        priority if (phase_new < PH_Q1)
        begin
            idx_wide    = phase_new;
            s1_neg_next = 1'b0;
        end
        else if (phase_new < PH_Q2)
        begin
            idx_wide    = PH_Q2 - phase_new;
            s1_neg_next = 1'b1;
        end
        else if (phase_new < PH_Q3)
        begin
            idx_wide    = phase_new - PH_Q2;
            s1_neg_next = 1'b1;
        end
        else
        begin
            idx_wide    = PH_TOP - phase_new;
            s1_neg_next = 1'b0;
        end
        rd_addr      = AW'(idx_wide);
        s1_idle_next = (level_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= 1'b1;
            agree_reg     <= '0;
            debounced_reg <= 1'b0;
            press_reg     <= '0;
            level_reg     <= '0;
            phase_reg     <= '0;
            tdiv_reg      <= '0;
        end
        else if (tick)
        begin
            last_raw_reg  <= last_raw_next;
            agree_reg     <= agree_next;
            debounced_reg <= debounced_next;
            press_reg     <= press_next;
            level_reg     <= level_next;
            phase_reg     <= phase_next;
            tdiv_reg      <= tdiv_next;
        end
    end

    // Table memory: one write or one read per transaction
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= table_value;
        if (tick && rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= tick && emit;
    end

    always_ff @(posedge clk)
    begin
        if (tick && emit)
        begin
            s1_idle_reg   <= s1_idle_next;
            s1_neg_reg    <= s1_neg_next;
            s1_level_reg  <= level_next;
            s1_stable_reg <= debounced_next;
        end
    end

    // Duty from table entry
    always_comb
    begin
        if (s1_idle_reg)
            duty_calc = DUTY_IDLE;
        else if (s1_neg_reg)
            duty_calc = DUTY_MID - {1'b0, rd_data_reg};
        else
            duty_calc = DUTY_MID + {1'b0, rd_data_reg};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            duty_reg       <= duty_calc;
            level_out_reg  <= s1_level_reg;
            stable_out_reg <= s1_stable_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_value   = duty_reg;
    assign speed_level  = level_out_reg;
    assign stable_level = stable_out_reg;

endmodule

// ----- dv/lbds_duty_checker.sv -----
// Checker for the LED breathing block: predicts duty transactions and compares them.
`timescale 1ns / 1ps
module lbds_duty_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 command,
    input  logic                 button_level,
    input  logic [5:0]           table_index,
    input  logic [7:0]           table_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  lbds_pkg::duty_t      duty_value,
    input  lbds_pkg::level_t     speed_level,
    input  logic                 stable_level,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  lbds_pkg::cfg_index_t cfg_index,
    input  lbds_pkg::cfg_data_t  cfg_data,
    output int unsigned          mismatches,
    output int unsigned          expected_left
);
    import lbds_pkg::*;

    typedef struct packed {
        duty_t  duty;
        level_t level;
        logic   stable;
    } duty_word_t;

    // Register copies
    logic [7:0]  debounce_cfg;
    logic [15:0] short_cfg;
    logic [15:0] long_cfg;
    logic [4:0]  divider_cfg;

    // Breathing state
    logic        last_raw_q;
    logic [7:0]  agree_q;
    logic        stable_q;
    logic [15:0] press_q;
    level_t      level_q;
    logic [7:0]  phase_q;
    logic [4:0]  div_q;
    logic [7:0]  qtable [0:QUARTER_POINTS];

    duty_word_t  pending_duties [$];
    duty_word_t  want;

    // Mirror the quarter wave into the quadrant the phase sits in
    function automatic duty_t duty_at_phase(int h);
        int q;
        q = QUARTER_POINTS;
        if (h < q)
            return DUTY_MID + duty_t'(qtable[h]);
        if (h < 2 * q)
            return DUTY_MID - duty_t'(qtable[2 * q - h]);
        if (h < 3 * q)
            return DUTY_MID - duty_t'(qtable[h - 2 * q]);
        return DUTY_MID + duty_t'(qtable[4 * q - h]);
    endfunction

    function automatic void flag(string what, int unsigned want_v, int unsigned got_v);
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    // One tick: divider, debounce, press logic, then the duty update
    task automatic advance_breathing(logic raw);
        int         next_phase;
        duty_word_t word;
        div_q = div_q + 5'd1;

        if (raw != last_raw_q) begin
            last_raw_q = raw;
            agree_q    = 8'd0;
        end
        else begin
            if (agree_q <= debounce_cfg && agree_q != 8'd255)
                agree_q = agree_q + 8'd1;
            if (agree_q == debounce_cfg)
                stable_q = raw;
        end

        if (!stable_q) begin
            if (press_q != 16'hFFFF)
                press_q = press_q + 16'd1;
        end
        else begin
            if (press_q >= long_cfg) begin
                level_q = '0;
                phase_q = '0;
            end
            else if (press_q >= short_cfg && level_q < LEVEL_MAX) begin
                level_q = level_q + 3'd1;
            end
            press_q = '0;
        end

        if (div_q != divider_cfg)
            return;
        div_q = '0;

        if (level_q != '0) begin
            next_phase = int'(phase_q) + (1 << (int'(level_q) - 1));
            phase_q    = (next_phase > 4 * QUARTER_POINTS) ? 8'd0 : 8'(next_phase);
            word.duty  = duty_at_phase(int'(phase_q));
        end
        else begin
            word.duty = DUTY_IDLE;
        end
        word.level  = level_q;
        word.stable = stable_q;
        pending_duties.push_back(word);
    endtask

    // Watch all three channels on the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            debounce_cfg  = DEBOUNCE_COUNT_RST;
            short_cfg     = SHORT_PRESS_TICKS_RST;
            long_cfg      = LONG_PRESS_TICKS_RST;
            divider_cfg   = UPDATE_DIVIDER_RST;
            last_raw_q    = 1'b1;
            agree_q       = '0;
            stable_q      = 1'b0;
            press_q       = '0;
            level_q       = '0;
            phase_q       = '0;
            div_q         = '0;
            for (int i = 0; i <= QUARTER_POINTS; i++)
                qtable[i] = '0;
            pending_duties.delete();
            mismatches    = 0;
            expected_left = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE_COUNT:    debounce_cfg = cfg_data[7:0];
                    CFG_SHORT_PRESS_TICKS: short_cfg    = cfg_data;
                    CFG_LONG_PRESS_TICKS:  long_cfg     = cfg_data;
                    CFG_UPDATE_DIVIDER:    divider_cfg  = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                if (command == CMD_TABLE_WRITE) begin
                    if (table_index <= QUARTER_POINTS)
                        qtable[table_index] = table_value;
                end
                else begin
                    advance_breathing(button_level);
                end
            end

            if (out_valid && out_ready) begin
                if (pending_duties.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected duty transaction: expected none, got %0d/%0d/%0d",
                             $time, duty_value, speed_level, stable_level);
                end
                else begin
                    want = pending_duties.pop_front();
                    if (duty_value !== want.duty)
                        flag("duty_value", want.duty, duty_value);
                    if (speed_level !== want.level)
                        flag("speed_level", want.level, speed_level);
                    if (stable_level !== want.stable)
                        flag("stable_level", want.stable, stable_level);
                end
            end

            expected_left = pending_duties.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the LED breathing block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import lbds_pkg::*;

    localparam int         TABLE_TOP  = QUARTER_POINTS;
    localparam cfg_index_t CFG_UNUSED = cfg_index_t'(8'hFF);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic        button_level;
    logic [5:0]  table_index;
    logic [7:0]  table_value;
    logic        out_valid;
    logic        out_ready;
    duty_t       duty_value;
    level_t      speed_level;
    logic        stable_level;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    cfg_data_t   cfg_data;

    int unsigned mismatches;
    int unsigned expected_left;

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned write_mix;
    int unsigned item_count;
    logic        pressure_on;

    // Thresholds currently loaded, used to size the presses
    int unsigned db_cur;
    int unsigned sp_cur;
    int unsigned lp_cur;

    led_breathing_debounced_speed i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .button_level (button_level),
        .table_index  (table_index),
        .table_value  (table_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty_value   (duty_value),
        .speed_level  (speed_level),
        .stable_level (stable_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lbds_duty_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .button_level  (button_level),
        .table_index   (table_index),
        .table_value   (table_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .duty_value    (duty_value),
        .speed_level   (speed_level),
        .stable_level  (stable_level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off under pressure
    initial
    begin : drain
        bit drain_held;
        drain_held = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_on && !drain_held)
            begin
                drain_held = 1'b1;
                out_ready <= 1'b0;
                repeat (200) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // One input transaction, with random gaps ahead of it
    task automatic send_item(command_t cmd, logic btn, logic [5:0] idx, logic [7:0] val);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        button_level <= btn;
        table_index  <= idx;
        table_value  <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        item_count++;
    endtask

    // Tick with a button sample; sometimes a table write slips in first
    task automatic send_tick(logic btn);
        if ($urandom_range(99) < write_mix)
            send_item(CMD_TABLE_WRITE, 1'($urandom_range(1)), 6'($urandom_range(63)),
                      8'($urandom_range(255)));
        send_item(CMD_TICK, btn, 6'($urandom_range(63)), 8'($urandom_range(255)));
    endtask

    // Drop valid and let the block drain before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_left != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int unsigned db, int unsigned sp, int unsigned lp, int unsigned dv);
        write_reg(CFG_DEBOUNCE_COUNT, cfg_data_t'(db));
        write_reg(CFG_SHORT_PRESS_TICKS, cfg_data_t'(sp));
        write_reg(CFG_LONG_PRESS_TICKS, cfg_data_t'(lp));
        write_reg(CFG_UPDATE_DIVIDER, cfg_data_t'(dv));
        db_cur = db;
        sp_cur = sp;
        lp_cur = lp;
    endtask

    task automatic set_idling(int unsigned snd, int unsigned rcv);
        snd_idle_pct = snd;
        rcv_idle_pct <= rcv;
    endtask

    // Mostly bounced presses of short, medium and long length; some noise
    task automatic run_segment(int unsigned n_items);
        int unsigned stop;
        int unsigned hold;
        int unsigned kind;
        stop = item_count + n_items;
        while (item_count < stop)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
            end
            else
            begin
                if (kind <= 3)
                    hold = $urandom_range(db_cur + 1, sp_cur + db_cur + 2);
                else if (kind <= 6)
                    hold = $urandom_range(sp_cur, lp_cur);
                else
                    hold = $urandom_range(lp_cur, lp_cur + 6);
                repeat ($urandom_range(2))
                begin
                    send_tick(1'b0);
                    send_tick(1'b1);
                end
                repeat (hold) send_tick(1'b0);
                repeat ($urandom_range(1)) send_tick(1'b1);
                repeat ($urandom_range(db_cur + 1, db_cur + 8)) send_tick(1'b1);
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned sp;
        logic        press_seq [$];
        in_valid     = 1'b0;
        command      = CMD_TICK;
        button_level = 1'b1;
        table_index  = '0;
        table_value  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEBOUNCE_COUNT;
        cfg_data     = '0;
        rst_n        = 1'b0;
        pressure_on  = 1'b0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_mix    = 0;
        item_count   = 0;
        db_cur       = DEBOUNCE_COUNT_RST;
        sp_cur       = SHORT_PRESS_TICKS_RST;
        lp_cur       = LONG_PRESS_TICKS_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idling(13, 57);

        // Reset settings, button released: level stays 0, idle duty only
        repeat (40) send_tick(1'b1);

        // Load the whole quarter wave, peak at entry 0 and zero at the top
        for (int i = 0; i <= TABLE_TOP; i++)
            send_item(CMD_TABLE_WRITE, 1'($urandom_range(1)), 6'(i),
                      8'(255 - (i * i * 255) / 1024));

        // Smallest thresholds, duty update on every tick
        settle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        configure(1, 1, 6, 1);

        // Out-of-range table writes must leave the table alone
        send_item(CMD_TABLE_WRITE, 1'b0, 6'd33, 8'hFF);
        send_item(CMD_TABLE_WRITE, 1'b1, 6'd63, 8'hA5);
        // two short presses, a long press that clears, then a one-tick glitch
        press_seq = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                      1'b0, 1'b1};
        foreach (press_seq[k])
            send_tick(press_seq[k]);

        // Random presses under changing settings and idling
        write_mix = 5;
        for (int seg = 0; seg < 6; seg++)
        begin
            settle();
            if (seg == 2)
                set_idling(57, 13);
            else if (seg == 4)
                set_idling(0, 0);
            sp = $urandom_range(2, 10);
            configure($urandom_range(1, 4), sp, sp + $urandom_range(8, 40),
                      $urandom_range(1, 5));
            run_segment(80);
        end

        // Result on every tick while the output is held off: input must stall
        settle();
        configure(1, 1, 1, 1);
        pressure_on <= 1'b1;
        run_segment(60);

        // Zero debounce count and zero divider
        settle();
        configure(0, SHORT_PRESS_TICKS_RST, LONG_PRESS_TICKS_RST, 0);
        repeat (100) send_tick(1'($urandom_range(1)));

        // Largest settings: agree counter saturates and the stable level follows
        settle();
        write_mix = 0;
        configure(255, 16'hFFFF, 16'hFFFF, 31);
        repeat (270) send_tick(1'b0);
        repeat (20) send_tick(1'b1);

        settle();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
